@@ design/dbl_pkg.sv @@
`timescale 1ns / 1ps
package dbl_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_DEPTH_BITS = 24;

	localparam int QUO_BITS = 17;
	localparam logic [31:0] NEAR_RESET   = 32'd6554;
	localparam logic [31:0] FAR_RESET    = 32'd655360;
	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [1:0] {
		REG_NEAR   = 2'd0,
		REG_FAR    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [23:0] depth_sample;
		logic [11:0] pixel_row;
		logic [11:0] pixel_col;
	} sample_t;

	typedef struct packed {
		logic [23:0] out_address;
		logic [15:0] distance_mm;
		logic        far_clipped;
		logic        range_saturated;
	} result_t;

	typedef struct packed {
		logic [23:0] addr;
		logic        clip;
		logic        sat;
		logic        far_zero;
	} side_t;

endpackage

@@ design/dbl_div.sv @@
`timescale 1ns / 1ps
module dbl_div #(
	parameter int DW = 56,
	parameter int QW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [DW+QW-1:0]    in_rem,
	input  logic [DW-1:0]       in_den,
	input  dbl_pkg::side_t      in_side,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [QW-1:0]       out_q,
	output dbl_pkg::side_t      out_side
);
	import dbl_pkg::*;

	localparam int RW = DW + QW;

	logic [RW-1:0] rem_q  [0:QW];
	logic [DW-1:0] den_q  [0:QW];
	logic [QW-1:0] quo_q  [0:QW];
	side_t         side_q [0:QW];
	logic [QW:0]   vld_q;
	logic [QW:0]   en;

	always_comb begin
		rem_q[0]  = in_rem;
		den_q[0]  = in_den;
		quo_q[0]  = '0;
		side_q[0] = in_side;
		vld_q[0]  = in_valid;
	end

	always_comb begin
		en[0] = 1'b0;
		en[QW] = !vld_q[QW] || !out_stall;
		for (int k = QW - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_stall = !en[1];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BIT = QW - 1 - k;
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_q[k]) << BIT;
		assign ge  = rem_q[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en[k+1]) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				rem_q[k+1]  <= ge ? rem_q[k] - dsh : rem_q[k];
				den_q[k+1]  <= den_q[k];
				side_q[k+1] <= side_q[k];
				quo_q[k+1]  <= quo_q[k] | (ge ? (QW'(1) << BIT) : '0);
			end
		end
	end

	assign out_valid = vld_q[QW];
	assign out_q     = quo_q[QW];
	assign out_side  = side_q[QW];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[QW] && !side_q[QW].sat && !side_q[QW].clip && !side_q[QW].far_zero
		|-> rem_q[QW] < RW'(den_q[QW]))
		else $error("remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[QW] && out_stall |=> vld_q[QW] && $stable(quo_q[QW]))
		else $error("stalled quotient changed");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[1])
		else $error("stall with empty first stage");

endmodule

@@ design/depth_buffer_linearizer.sv @@
`timescale 1ns / 1ps
// Depth buffer linearizer.
// Input channel: sample_valid / sample_stall with a sample_t beat (24-bit window
// depth, pixel row and column). Output channel: result_valid / result_stall with
// a result_t beat (flipped address, distance in mm, clip and saturation flags).
// Configuration: cfg_write with cfg_index (near, far, width, height) and
// cfg_data; write only while the pipeline is empty.
// Throughput: one beat per cycle while result_stall is low. From acceptance a
// beat passes the product, denominator and clip-test registers, one stage per
// quotient bit of the 17-bit divider, and the output register.
// Each stage holds only when full and its successor is held, so bubbles close up
// and a stalled receiver backs the pipeline up to sample_stall without loss.
// Reset clears all valid bits and loads the default near/far planes (0.1 m,
// 10 m) and a 640 x 480 frame.
module depth_buffer_linearizer #(
	parameter int MAX_WIDTH  = dbl_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dbl_pkg::DEF_MAX_HEIGHT,
	parameter int DEPTH_BITS = dbl_pkg::DEF_DEPTH_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  dbl_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output dbl_pkg::result_t result,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import dbl_pkg::*;

	localparam int B  = DEPTH_BITS;
	localparam int DW = 32 + B;
	localparam int NW = 59 + B;
	localparam int LW = 39 + B;
	localparam int RW = DW + QUO_BITS;

	logic [31:0] near_q, far_q;
	logic [12:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RESET;
			far_q    <= FAR_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_NEAR:   near_q   <= cfg_data;
				REG_FAR:    far_q    <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				default:    ;
			endcase
		end
	end

	logic [12:0]  w_eff, h_eff;
	logic [B-1:0] s_in;
	logic [B:0]   s_comp;
	logic [23:0]  row_flip;

	assign w_eff    = (32'(width_q) > MAX_WIDTH) ? 13'(MAX_WIDTH) : width_q;
	assign h_eff    = (32'(height_q) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_q;
	assign s_in     = B'(sample.depth_sample);
	assign s_comp   = {1'b1, {B{1'b0}}} - {1'b0, s_in};
	assign row_flip = 24'(h_eff) - 24'd1 - 24'(sample.pixel_row);

	logic v_s1, v_s2, v_s3, en1, en2, en3, div_stall;

	// stage 1: products
	logic [DW-1:0] p1_s1, p2_s1;
	logic [63:0]   fn_s1;
	logic [31:0]   near_s1;
	logic          fz_s1;
	logic [23:0]   addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			p1_s1   <= DW'(64'(far_q) * 64'(s_comp));
			p2_s1   <= DW'(64'(near_q) * 64'(s_in));
			fn_s1   <= 64'(far_q) * 64'(near_q);
			near_s1 <= near_q;
			fz_s1   <= far_q == '0;
			addr_s1 <= 24'(row_flip * 24'(w_eff)) + 24'(sample.pixel_col);
		end
	end

	// stage 2: denominator, numerator, clip bound
	logic [DW-1:0] den_s2;
	logic [NW-1:0] num_s2;
	logic [LW-1:0] lhs_s2;
	logic          fz_s2;
	logic [23:0]   addr_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			den_s2  <= p1_s1 + p2_s1;
			num_s2  <= (NW'(fn_s1) * NW'(2000)) << (B - 16);
			lhs_s2  <= (LW'(near_s1) * LW'(100)) << B;
			fz_s2   <= fz_s1;
			addr_s2 <= addr_s1;
		end
	end

	// stage 3: clip and saturation tests
	logic [RW-1:0] rem_s3;
	logic [DW-1:0] den_s3;
	side_t         side_s3;
	logic          clip_c, sat_c;

	assign clip_c = lhs_s2 > (LW'(den_s2) * LW'(99));
	assign sat_c  = num_s2 >= (NW'(den_s2) * NW'(131071));

	always_ff @(posedge clk) begin
		if (en3) begin
			rem_s3           <= RW'(num_s2);
			den_s3           <= den_s2;
			side_s3.addr     <= addr_s2;
			side_s3.far_zero <= fz_s2;
			side_s3.clip     <= !fz_s2 && clip_c;
			side_s3.sat      <= !fz_s2 && !clip_c && sat_c;
		end
	end

	assign en3 = !v_s3 || !div_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample_stall = !en1;

	logic                div_valid, div_out_stall;
	logic [QUO_BITS-1:0] div_q;
	side_t               div_side;

	dbl_div #(.DW(DW), .QW(QUO_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_stall  (div_stall),
		.in_rem    (rem_s3),
		.in_den    (den_s3),
		.in_side   (side_s3),
		.out_valid (div_valid),
		.out_stall (div_out_stall),
		.out_q     (div_q),
		.out_side  (div_side)
	);

	logic    res_valid_q;
	result_t res_q;
	logic    en_out;
	logic [QUO_BITS-1:0] q_round;

	assign en_out        = !res_valid_q || !result_stall;
	assign div_out_stall = !en_out;
	assign q_round       = div_q + QUO_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q.out_address     <= div_side.addr;
			res_q.far_clipped     <= div_side.clip;
			res_q.range_saturated <= div_side.sat;
			if (div_side.sat) begin
				res_q.distance_mm <= 16'hFFFF;
			end else if (div_side.clip || div_side.far_zero) begin
				res_q.distance_mm <= '0;
			end else begin
				res_q.distance_mm <= q_round[16:1];
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.far_clipped && result.range_saturated))
		else $error("clip and saturation both set");

	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.far_clipped |-> result.distance_mm == '0)
		else $error("clipped result not zero");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_saturated |-> result.distance_mm == 16'hFFFF)
		else $error("saturated result not full scale");

	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v_s1 && v_s2 && v_s3)
		else $error("input held with a bubble in the front stages");

endmodule

@@ dv/depth_buffer_linearizer_tb.sv @@
`timescale 1ns / 1ps
module depth_buffer_linearizer_tb;
	import dbl_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_BEATS    = 128;

	typedef struct {
		sample_t smp;
		bit      typed;
		result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	sample_t     sample;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] near_q16, far_q16;
	logic [12:0] frame_w, frame_h;

	result_t   pending_results[$];
	stim_row_t directed_rows[$];
	int        mismatches;
	int        idle_cycles;
	int        hold_cycles;
	bit        gaps_on;
	bit        cur_typed;
	result_t   cur_typed_res;

	depth_buffer_linearizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic result_t linearize(sample_t s);
		logic [63:0]  nr, fr, sv, den;
		logic [127:0] lhs, rhs, num, q;
		logic [23:0]  w, h;
		result_t      r;
		nr = 64'(near_q16);
		fr = 64'(far_q16);
		sv = 64'(s.depth_sample);
		w  = (frame_w > 13'd4096) ? 24'd4096 : 24'(frame_w);
		h  = (frame_h > 13'd4096) ? 24'd4096 : 24'(frame_h);
		r.out_address     = (h - 24'd1 - 24'(s.pixel_row)) * w + 24'(s.pixel_col);
		r.distance_mm     = '0;
		r.far_clipped     = 1'b0;
		r.range_saturated = 1'b0;
		if (fr != 0) begin
			den = fr * ((64'd1 << 24) - sv) + sv * nr;
			lhs = 128'(nr << 24) * 128'd100;
			rhs = 128'(den) * 128'd99;
			if (lhs > rhs) begin
				r.far_clipped = 1'b1;
			end else begin
				num = (128'(fr * nr) * 128'd2000) << 8;
				q = num / 128'(den);
				if (q >= 128'd131071) begin
					r.range_saturated = 1'b1;
					r.distance_mm = 16'hFFFF;
				end else begin
					r.distance_mm = 16'((q + 128'd1) >> 1);
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int      k;
		k = $urandom_range(0, 9);
		case (k)
			0: s.depth_sample = 24'd0;
			1: s.depth_sample = 24'hFFFFFF;
			2, 3, 4: s.depth_sample = 24'hFFFFFF - 24'($urandom_range(0, 65535));
			default: s.depth_sample = 24'($urandom);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			s.pixel_row = 12'($urandom);
			s.pixel_col = 12'($urandom);
		end else begin
			s.pixel_row = 12'($urandom_range(0, (frame_h > 1) ? frame_h - 1 : 0));
			s.pixel_col = 12'($urandom_range(0, (frame_w > 1) ? frame_w - 1 : 0));
		end
		return s;
	endfunction

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			REG_NEAR:   near_q16 = val;
			REG_FAR:    far_q16  = val;
			REG_WIDTH:  frame_w  = val[12:0];
			default:    frame_h  = val[12:0];
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_frame(logic [31:0] n, logic [31:0] f, logic [12:0] w, logic [12:0] h);
		sample_valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(REG_NEAR, n);
		write_reg(REG_FAR, f);
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_beat(sample_t s, bit typed, result_t tr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid  = 1'b1;
		sample        = s;
		cur_typed     = typed;
		cur_typed_res = tr;
		do
			@(posedge clk);
		while (sample_stall);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		result_t got, want;
		bit      ok;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				pending_results.push_back(cur_typed ? cur_typed_res : linearize(sample));
			end
			if (result_valid && !result_stall) begin
				got = result;
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat %h", got);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					ok = (got.out_address == want.out_address) &&
						(got.distance_mm == want.distance_mm) &&
						(got.far_clipped == want.far_clipped) &&
						(got.range_saturated == want.range_saturated);
					if (!ok) begin
						if (mismatches < 10)
							$display("mismatch: addr %h/%h mm %0d/%0d clip %b/%b sat %b/%b",
								want.out_address, got.out_address,
								want.distance_mm, got.distance_mm,
								want.far_clipped, got.far_clipped,
								want.range_saturated, got.range_saturated);
						mismatches++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		int r;
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else if (!gaps_on) begin
			result_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			result_stall <= (r < 25) || (r >= 98 && $urandom_range(0, 1) == 1);
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("depth_buffer_linearizer_tb: FAIL");
			$finish;
		end
	end

	initial begin
		result_t   none;
		stim_row_t row;
		sample_t   s;
		logic [31:0] f, n;
		none = '0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_NEAR;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_cycles = 0;
		gaps_on = 1'b1;
		cur_typed = 1'b0;
		cur_typed_res = '0;
		near_q16 = NEAR_RESET;
		far_q16  = FAR_RESET;
		frame_w  = WIDTH_RESET;
		frame_h  = HEIGHT_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset frame: near 0.1 m, 640 x 480
		directed_rows.push_back('{'{24'd0, 12'd0, 12'd0}, 1'b1, '{24'd306560, 16'd100, 1'b0, 1'b0}});
		directed_rows.push_back('{'{24'hFFFFFF, 12'd0, 12'd0}, 1'b1, '{24'd306560, 16'd0, 1'b1, 1'b0}});
		directed_rows.push_back('{'{24'd0, 12'd479, 12'd639}, 1'b1, '{24'd639, 16'd100, 1'b0, 1'b0}});
		directed_rows.push_back('{'{24'hFFFFFF, 12'hFFF, 12'hFFF}, 1'b0, none});
		directed_rows.push_back('{'{24'h800000, 12'd100, 12'd200}, 1'b0, none});
		directed_rows.push_back('{'{24'hFFF000, 12'd1, 12'd1}, 1'b0, none});
		directed_rows.push_back('{'{24'hFFFC00, 12'd480, 12'd640}, 1'b0, none});
		directed_rows.push_back('{'{24'hFFFF00, 12'h555, 12'hAAA}, 1'b0, none});
		directed_rows.push_back('{'{24'h555555, 12'hAAA, 12'h555}, 1'b0, none});
		directed_rows.push_back('{'{24'hAAAAAA, 12'd0, 12'd1}, 1'b0, none});
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_beat(row.smp, row.typed, row.res);
		end

		// far plane zero: distance and flags all clear
		set_frame(32'h0001_0000, 32'd0, 13'd1, 13'd1);
		send_beat('{24'd0, 12'd0, 12'd0}, 1'b1, '{24'd0, 16'd0, 1'b0, 1'b0});
		send_beat('{24'hFFFFFF, 12'd0, 12'd0}, 1'b1, '{24'd0, 16'd0, 1'b0, 1'b0});
		send_beat('{24'h123456, 12'd0, 12'd5}, 1'b1, '{24'd5, 16'd0, 1'b0, 1'b0});

		// near equal to far at full scale: clipped
		set_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd8191, 13'd8191);
		send_beat('{24'd0, 12'd0, 12'd0}, 1'b1, '{24'hFFF000, 16'd0, 1'b1, 1'b0});
		send_beat('{24'h000001, 12'hFFF, 12'hFFF}, 1'b0, none);
		send_beat('{24'hFFFFFF, 12'd0, 12'hFFF}, 1'b0, none);
		cur_typed = 1'b0;

		sample_valid = 1'b0;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: set_frame(NEAR_RESET, FAR_RESET, WIDTH_RESET, HEIGHT_RESET);
				1: set_frame(32'd1, 32'hFFFF_FFFF, 13'd4096, 13'd4096);
				2: set_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd8191, 13'd8191);
				3: set_frame(32'd655360, 32'd6554, 13'd0, 13'd0);
				4: set_frame(32'd1, 32'd1, 13'd1, 13'd1);
				5: set_frame(32'h0001_0000, 32'd0, 13'd100, 13'd50);
				default: begin
					f = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(2, 32'h00FF_FFFF));
					if (f < 2)
						f = 2;
					n = 32'($urandom_range(1, f - 1));
					set_frame(n, f, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
				end
			endcase
			gaps_on = (ph % 4) != 3;
			if (ph == 1)
				hold_cycles = 400;
			for (int k = 0; k < PHASE_BEATS; k++) begin
				s = random_sample();
				send_beat(s, 1'b0, none);
			end
			sample_valid = 1'b0;
		end

		sample_valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("depth_buffer_linearizer_tb: PASS");
		else
			$display("depth_buffer_linearizer_tb: FAIL");
		$finish;
	end

endmodule
